@@ rtl/core/arfg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arfg_pkg
// Shared widths, codes and constants for the audio sample ring with gain.
// ----------------------------------------------------------------------------
package arfg_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int FILL_W     = 13;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam int DEFAULT_RING_DEPTH = 4096;

    // Q1.15 gain limits
    localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd32768;
    localparam logic [GAIN_W-1:0] GAIN_FLOOR = 16'd32;

    // Request operation codes
    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MUTE = 1'd1;

endpackage

@@ rtl/core/audio_ring_fifo_with_gain.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_ring_fifo_with_gain
// PCM sample ring buffer with Q1.15 gain on writes and overwrite of the
// oldest sample when full.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one request: write (s_sample_in scaled and stored),
//   read (pop oldest sample) or clear (empty the ring). Every request gives
//   exactly one result on the m_ channel with the fill level after it.
//   cfg_ channel writes gain (index 0) and mute (index 1); write only while
//   no request is in flight.
//   A request is accepted in ST_IDLE, which issues the gain multiply and
//   the ring memory read; in ST_EXEC, once the output register is free, it
//   writes back the memory and pointers and loads the output register. The
//   ring memory has one write port and one registered read port. A new
//   request is not taken until the current one has completed.
//   A result waiting in the output register does not block the next request
//   from being taken; its completion holds until the output register frees.
//   Reset (aresetn low, synchronous) empties the ring, zeroes the pointers,
//   sets gain to unity and clears mute. Stored samples are not cleared.
// ----------------------------------------------------------------------------
module audio_ring_fifo_with_gain #(
    parameter int RING_DEPTH = arfg_pkg::DEFAULT_RING_DEPTH
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // request channel
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic        [arfg_pkg::OP_W-1:0]        s_operation,
    input  logic signed [arfg_pkg::SAMPLE_W-1:0]    s_sample_in,
    // result channel
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [arfg_pkg::SAMPLE_W-1:0]    m_sample_out,
    output logic                                    m_sample_valid,
    output logic                                    m_overwrote_oldest,
    output logic        [arfg_pkg::FILL_W-1:0]      m_fill_level,
    // configuration channel
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic        [arfg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic        [arfg_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import arfg_pkg::*;

    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RING_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [GAIN_W-1:0] gain_reg, gain_next;
    logic              mute_reg, mute_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [PTR_W-1:0]  rp_reg, rp_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic                    m_valid_reg, m_valid_next;
    logic signed [SAMPLE_W-1:0] out_sample_reg, out_sample_next;
    logic                    out_svalid_reg, out_svalid_next;
    logic                    out_over_reg, out_over_next;
    logic [CNT_W-1:0]        out_cnt_reg, out_cnt_next;

    logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
    logic [SAMPLE_W-1:0] mem_rd_reg;
    logic                mem_we;
    logic                mem_re;

    logic                       accept;
    logic                       done;
    logic                       keep;
    logic signed [SAMPLE_W-1:0] sample_scaled;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign done      = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);
    assign mem_re    = accept && (s_operation == OP_READ);

    // Gain multiply, loaded at accept
    arfg_scale u_scale (
        .aclk          (aclk),
        .load          (accept),
        .sample_in     (s_sample_in),
        .gain          (gain_reg),
        .mute          (mute_reg),
        .keep          (keep),
        .sample_scaled (sample_scaled)
    );

    // Configuration registers
    always_comb begin
        gain_next = gain_reg;
        mute_next = mute_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_GAIN: gain_next = cfg_data;
                REG_MUTE: mute_next = cfg_data[0];
                default:  ;
            endcase
        end
    end

    // Sequencer and ring update at completion
    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        wp_next         = wp_reg;
        rp_next         = rp_reg;
        cnt_next        = cnt_reg;
        mem_we          = 1'b0;
        m_valid_next    = m_ready ? 1'b0 : m_valid_reg;
        out_sample_next = out_sample_reg;
        out_svalid_next = out_svalid_reg;
        out_over_next   = out_over_reg;
        out_cnt_next    = out_cnt_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_next    = s_operation;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (done) begin
                    out_sample_next = '0;
                    out_svalid_next = 1'b0;
                    out_over_next   = 1'b0;
                    case (op_reg)
                        OP_WRITE: begin
                            if (keep) begin
                                mem_we  = 1'b1;
                                wp_next = (wp_reg == PTR_LAST) ? '0 : wp_reg + 1'b1;
                                if (cnt_reg == CNT_FULL) begin
                                    rp_next       = (rp_reg == PTR_LAST) ? '0 : rp_reg + 1'b1;
                                    out_over_next = 1'b1;
                                end else begin
                                    cnt_next = cnt_reg + 1'b1;
                                end
                            end
                        end
                        OP_READ: begin
                            if (cnt_reg != '0) begin
                                out_sample_next = mem_rd_reg;
                                out_svalid_next = 1'b1;
                                rp_next  = (rp_reg == PTR_LAST) ? '0 : rp_reg + 1'b1;
                                cnt_next = cnt_reg - 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            wp_next  = '0;
                            rp_next  = '0;
                            cnt_next = '0;
                        end
                        default: ;
                    endcase
                    out_cnt_next = cnt_next;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            gain_reg    <= GAIN_UNITY;
            mute_reg    <= 1'b0;
            wp_reg      <= '0;
            rp_reg      <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            gain_reg    <= gain_next;
            mute_reg    <= mute_next;
            wp_reg      <= wp_next;
            rp_reg      <= rp_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        out_sample_reg <= out_sample_next;
        out_svalid_reg <= out_svalid_next;
        out_over_reg   <= out_over_next;
        out_cnt_reg    <= out_cnt_next;
    end

    // Ring memory write port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring_mem[wp_reg] <= sample_scaled;
        end
    end

    // Ring memory read port, registered
    always_ff @(posedge aclk) begin
        if (mem_re) begin
            mem_rd_reg <= ring_mem[rp_reg];
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_sample_out       = out_sample_reg;
    assign m_sample_valid     = out_svalid_reg;
    assign m_overwrote_oldest = out_over_reg;
    assign m_fill_level       = FILL_W'(out_cnt_reg);

endmodule

@@ rtl/core/arfg_scale.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arfg_scale
// Gain stage: registered Q1.15 multiply, then truncation toward zero and
// saturation to 16 bits. Also registers whether the write is kept.
// ----------------------------------------------------------------------------
module arfg_scale (
    input  logic                                  aclk,
    input  logic                                  load,
    input  logic signed [arfg_pkg::SAMPLE_W-1:0]  sample_in,
    input  logic        [arfg_pkg::GAIN_W-1:0]    gain,
    input  logic                                  mute,
    output logic                                  keep,
    output logic signed [arfg_pkg::SAMPLE_W-1:0]  sample_scaled
);
    import arfg_pkg::*;

    logic        [GAIN_W-1:0] gain_clamped;
    logic signed [32:0]       product_full;
    logic signed [31:0]       product_reg;
    logic signed [31:0]       product_next;
    logic                     keep_reg;
    logic                     keep_next;
    logic signed [31:0]       rounded;
    logic signed [16:0]       quotient;

    // Gain above unity acts as unity; low gain or mute drops the write
    always_comb begin
        gain_clamped = (gain > GAIN_UNITY) ? GAIN_UNITY : gain;
        product_full = sample_in * $signed({1'b0, gain_clamped});
        product_next = product_full[31:0];
        keep_next    = !mute && (gain_clamped > GAIN_FLOOR);
    end

    // Product register, loaded when a request is taken
    always_ff @(posedge aclk) begin
        if (load) begin
            product_reg <= product_next;
            keep_reg    <= keep_next;
        end
    end

    // Divide by 2^15 toward zero, then clamp
    always_comb begin
        rounded  = product_reg + (product_reg[31] ? 32'sd32767 : 32'sd0);
        quotient = 17'(rounded >>> 15);
        if (quotient > 17'sd32767) begin
            sample_scaled = 16'sh7fff;
        end else if (quotient < -17'sd32768) begin
            sample_scaled = 16'sh8000;
        end else begin
            sample_scaled = quotient[15:0];
        end
    end

    assign keep = keep_reg;

endmodule

@@ rtl/core/arfg_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arfg_port_checks
// Port-level checks for the audio sample ring, bound to the top level.
// ----------------------------------------------------------------------------
module arfg_port_checks #(
    parameter int RING_DEPTH = arfg_pkg::DEFAULT_RING_DEPTH
) (
    input logic                                   aclk,
    input logic                                   aresetn,
    input logic                                   m_valid,
    input logic                                   m_ready,
    input logic signed [arfg_pkg::SAMPLE_W-1:0]   m_sample_out,
    input logic                                   m_sample_valid,
    input logic                                   m_overwrote_oldest,
    input logic        [arfg_pkg::FILL_W-1:0]     m_fill_level
);
    import arfg_pkg::*;

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(RING_DEPTH);

    // Result held until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_fill_level)
            && $stable(m_sample_out))
        else $error("result dropped or changed while stalled");

    // A read result never reports an overwrite
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_sample_valid && m_overwrote_oldest))
        else $error("sample_valid and overwrote_oldest both set");

    // Non-zero sample only on a successful read
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_sample_valid |-> m_sample_out == '0)
        else $error("sample_out non-zero without sample_valid");

    // Overwrite only happens with a full ring
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overwrote_oldest |-> m_fill_level == FILL_FULL)
        else $error("overwrite reported with ring not full");

endmodule

bind audio_ring_fifo_with_gain arfg_port_checks #(
    .RING_DEPTH (RING_DEPTH)
) u_arfg_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_sample_out       (m_sample_out),
    .m_sample_valid     (m_sample_valid),
    .m_overwrote_oldest (m_overwrote_oldest),
    .m_fill_level       (m_fill_level)
);

@@ tb/arfg_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arfg_checker
// Passive scoreboard for the audio sample ring with gain. It follows the
// configuration and request channels and keeps its own copy of the ring and
// the gain and mute settings. It checks every result against the oldest
// pending prediction, field by field.
// ----------------------------------------------------------------------------
module arfg_checker #(
    parameter int RING_DEPTH = arfg_pkg::DEFAULT_RING_DEPTH
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    input  logic                                    s_ready,
    input  logic        [arfg_pkg::OP_W-1:0]        s_operation,
    input  logic signed [arfg_pkg::SAMPLE_W-1:0]    s_sample_in,
    input  logic                                    m_valid,
    input  logic                                    m_ready,
    input  logic signed [arfg_pkg::SAMPLE_W-1:0]    m_sample_out,
    input  logic                                    m_sample_valid,
    input  logic                                    m_overwrote_oldest,
    input  logic        [arfg_pkg::FILL_W-1:0]      m_fill_level,
    input  logic                                    cfg_valid,
    input  logic                                    cfg_ready,
    input  logic        [arfg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic        [arfg_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                                      mismatch_count,
    output int                                      pending_results
);
    import arfg_pkg::*;

    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;
    localparam int MAX_PRINTED = 100;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       sample_ok;
        logic                       overwrote;
        logic [FILL_W-1:0]          fill;
    } ring_result_t;

    // Shadow copy of the ring and its settings
    logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
    int unsigned         wr_ptr;
    int unsigned         rd_ptr;
    int unsigned         held;
    logic [GAIN_W-1:0]   gain_reg;
    logic                mute_reg;

    ring_result_t        expected_results [$];
    int                  result_index;

    function automatic int unsigned next_slot(int unsigned p);
        return (p + 1 >= RING_DEPTH) ? 0 : p + 1;
    endfunction

    // Q1.15 scaling, truncated toward zero, then clamped to 16 bits
    function automatic logic signed [SAMPLE_W-1:0] apply_gain(
        logic signed [SAMPLE_W-1:0] smp, int g);
        int prod;
        int q;
        prod = int'(smp) * g;
        q = prod / int'(GAIN_UNITY);
        if (q > SAMPLE_MAX) q = SAMPLE_MAX;
        if (q < SAMPLE_MIN) q = SAMPLE_MIN;
        return q[SAMPLE_W-1:0];
    endfunction

    // Advance the shadow ring by one request and return its result
    function automatic ring_result_t step_ring(logic [OP_W-1:0] op,
                                               logic signed [SAMPLE_W-1:0] smp);
        ring_result_t r;
        int g;
        r = '0;
        // gain above unity acts as unity
        g = (gain_reg > GAIN_UNITY) ? int'(GAIN_UNITY) : int'(gain_reg);
        case (op)
            OP_WRITE: begin
                // muted or near-silent gain drops the write
                if (!mute_reg && g > int'(GAIN_FLOOR)) begin
                    ring_mem[wr_ptr] = apply_gain(smp, g);
                    wr_ptr = next_slot(wr_ptr);
                    if (held < RING_DEPTH) begin
                        held++;
                    end else begin
                        // full: the oldest sample is lost
                        rd_ptr = next_slot(rd_ptr);
                        r.overwrote = 1'b1;
                    end
                end
            end
            OP_READ: begin
                if (held > 0) begin
                    r.sample    = ring_mem[rd_ptr];
                    r.sample_ok = 1'b1;
                    rd_ptr      = next_slot(rd_ptr);
                    held--;
                end
            end
            OP_CLEAR: begin
                wr_ptr = 0;
                rd_ptr = 0;
                held   = 0;
            end
            default: begin
                // unused code: fill level only
            end
        endcase
        r.fill = held[FILL_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED)
            $display("[%0t] result %0d: %s", $time, result_index, msg);
        mismatch_count++;
    endtask

    // Track config writes, check results, predict new requests
    always @(posedge aclk) begin : watch
        ring_result_t want;
        if (!aresetn) begin
            wr_ptr         = 0;
            rd_ptr         = 0;
            held           = 0;
            gain_reg       = GAIN_UNITY;
            mute_reg       = 1'b0;
            result_index   = 0;
            mismatch_count = 0;
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_GAIN)
                    gain_reg = cfg_data[GAIN_W-1:0];
                else if (cfg_index == REG_MUTE)
                    mute_reg = cfg_data[0];
            end

            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no request pending");
                end else begin
                    want = expected_results.pop_front();
                    if (m_sample_out !== want.sample)
                        report_mismatch($sformatf("sample_out got %0d expected %0d",
                                                  m_sample_out, want.sample));
                    if (m_sample_valid !== want.sample_ok)
                        report_mismatch($sformatf("sample_valid got %0b expected %0b",
                                                  m_sample_valid, want.sample_ok));
                    if (m_overwrote_oldest !== want.overwrote)
                        report_mismatch($sformatf("overwrote_oldest got %0b expected %0b",
                                                  m_overwrote_oldest, want.overwrote));
                    if (m_fill_level !== want.fill)
                        report_mismatch($sformatf("fill_level got %0d expected %0d",
                                                  m_fill_level, want.fill));
                end
                result_index++;
            end

            if (s_valid && s_ready)
                expected_results.push_back(step_ring(s_operation, s_sample_in));
        end
        pending_results <= expected_results.size();
    end

endmodule

@@ tb/tb_audio_ring_fifo_with_gain.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_audio_ring_fifo_with_gain
// Stimulus and verdict for the audio sample ring with gain. A directed run of
// edge samples, empty reads, clears and the unused code is followed by
// phases of bursty random traffic under a range of gain and mute settings.
// Both channels idle at random; the result side also holds off for long
// stretches so that the request side backs up.
// ----------------------------------------------------------------------------
module tb_audio_ring_fifo_with_gain;
    import arfg_pkg::*;

    localparam int RING_DEPTH  = DEFAULT_RING_DEPTH;
    localparam int CYCLE_LIMIT = 600000;
    localparam int LONG_HOLD   = 150;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic                       aclk        = 1'b0;
    logic                       aresetn     = 1'b0;
    logic                       s_valid     = 1'b0;
    logic                       s_ready;
    logic [OP_W-1:0]            s_operation = OP_WRITE;
    logic signed [SAMPLE_W-1:0] s_sample_in = '0;
    logic                       m_valid;
    logic                       m_ready     = 1'b0;
    logic signed [SAMPLE_W-1:0] m_sample_out;
    logic                       m_sample_valid;
    logic                       m_overwrote_oldest;
    logic [FILL_W-1:0]          m_fill_level;
    logic                       cfg_valid   = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index   = REG_GAIN;
    logic [CFG_DATA_W-1:0]      cfg_data    = '0;

    int mismatch_count;
    int pending_results;
    int cycle_count   = 0;
    int results_taken = 0;
    bit send_idle     = 1'b1;

    audio_ring_fifo_with_gain #(
        .RING_DEPTH(RING_DEPTH)
    ) u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_operation        (s_operation),
        .s_sample_in        (s_sample_in),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_sample_out       (m_sample_out),
        .m_sample_valid     (m_sample_valid),
        .m_overwrote_oldest (m_overwrote_oldest),
        .m_fill_level       (m_fill_level),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    arfg_checker #(
        .RING_DEPTH(RING_DEPTH)
    ) u_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_operation        (s_operation),
        .s_sample_in        (s_sample_in),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_sample_out       (m_sample_out),
        .m_sample_valid     (m_sample_valid),
        .m_overwrote_oldest (m_overwrote_oldest),
        .m_fill_level       (m_fill_level),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .mismatch_count     (mismatch_count),
        .pending_results    (pending_results)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: random stalls, stretches without stalls, long hold-offs
    initial begin : result_sink
        int  stall;
        bit  stall_on;
        stall_on = 1'b1;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (results_taken % 64 == 0)
                stall_on = ($urandom_range(0, 3) != 0);
            if (results_taken == 200 || results_taken == 1200)
                stall = LONG_HOLD;
            else
                stall = stall_on ? $urandom_range(0, 8) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            results_taken++;
        end
    end

    // One request, preceded by a random gap when send_idle is set
    task automatic send_request(input logic [OP_W-1:0] op,
                                input logic signed [SAMPLE_W-1:0] smp);
        int gap;
        gap = send_idle ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_sample_in <= smp;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    // Stop offering and wait until every predicted result has arrived
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_volume(input logic [GAIN_W-1:0] gain, input logic mute);
        write_register(REG_GAIN, gain);
        write_register(REG_MUTE, {{(CFG_DATA_W-1){1'b0}}, mute});
    endtask

    // Mostly random samples, with the edge values mixed in
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        logic [31:0] raw;
        raw = $urandom;
        case ($urandom_range(0, 15))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            4:       return 16'sh0001;
            default: return raw[SAMPLE_W-1:0];
        endcase
    endfunction

    // Bursts of writes and reads, with clears and noise in between
    task automatic run_traffic(input int count);
        int              sent;
        int              burst;
        int              kind;
        int              k;
        logic [OP_W-1:0] any_op;
        sent = 0;
        while (sent < count) begin
            kind      = $urandom_range(0, 19);
            burst     = $urandom_range(1, 24);
            send_idle = ($urandom_range(0, 3) != 0);
            if (kind < 9) begin
                for (k = 0; k < burst; k++) send_request(OP_WRITE, pick_sample());
                sent += burst;
            end else if (kind < 16) begin
                for (k = 0; k < burst; k++) send_request(OP_READ, pick_sample());
                sent += burst;
            end else if (kind < 18) begin
                for (k = 0; k < burst; k++) begin
                    any_op = OP_W'($urandom_range(0, 3));
                    send_request(any_op, pick_sample());
                end
                sent += burst;
            end else if (kind == 18) begin
                send_request(OP_CLEAR, pick_sample());
                sent++;
            end else begin
                send_request(OP_UNUSED, pick_sample());
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        int                k;
        logic [GAIN_W-1:0] rand_gain;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty read, unused code, sample extremes, clear
        send_idle = 1'b1;
        send_request(OP_READ,   16'sh1234);
        send_request(OP_UNUSED, 16'sh7FFF);
        send_request(OP_WRITE,  16'sh7FFF);
        send_request(OP_WRITE,  16'sh8000);
        send_request(OP_WRITE,  16'sh0000);
        send_request(OP_WRITE,  16'shFFFF);
        send_request(OP_WRITE,  16'sh0001);
        send_request(OP_WRITE,  16'sh5555);
        send_request(OP_WRITE,  16'shAAAA);
        send_request(OP_READ,   16'sh0000);
        send_request(OP_READ,   16'shFFFF);
        send_request(OP_READ,   16'sh8000);
        send_request(OP_CLEAR,  16'sh0000);
        send_request(OP_READ,   16'sh0000);
        send_request(OP_WRITE,  16'sd100);
        send_request(OP_WRITE,  -16'sd100);
        send_request(OP_UNUSED, 16'sh8000);
        send_request(OP_READ,   16'sh7FFF);
        send_request(OP_READ,   16'sh0000);
        send_request(OP_READ,   16'sh0000);
        send_request(OP_CLEAR,  16'sh7FFF);
        drain_results();

        // Gain above unity clamps to unity
        set_volume(16'hFFFF, 1'b0);
        run_traffic(200);
        drain_results();

        // Muted: every write dropped
        set_volume(GAIN_UNITY, 1'b1);
        run_traffic(120);
        drain_results();

        // At the drop threshold, then just above it
        set_volume(GAIN_FLOOR, 1'b0);
        run_traffic(120);
        drain_results();
        set_volume(GAIN_FLOOR + 16'd1, 1'b0);
        run_traffic(200);
        drain_results();

        // Zero gain
        set_volume(16'd0, 1'b0);
        run_traffic(100);
        drain_results();

        // Half gain and a value just over unity
        set_volume(16'd16384, 1'b0);
        run_traffic(200);
        drain_results();
        set_volume(GAIN_UNITY + 16'd1, 1'b0);
        run_traffic(60);
        drain_results();

        // Random gains
        for (k = 0; k < 3; k++) begin
            rand_gain = GAIN_W'($urandom);
            set_volume(rand_gain, 1'b0);
            run_traffic(130);
            drain_results();
        end

        // Back to unity
        set_volume(GAIN_UNITY, 1'b0);
        run_traffic(200);
        drain_results();

        if (mismatch_count == 0 && pending_results == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/arfg_pkg.sv
rtl/core/arfg_scale.sv
rtl/core/audio_ring_fifo_with_gain.sv
rtl/core/arfg_checker.sv
tb/arfg_checker.sv
tb/tb_audio_ring_fifo_with_gain.sv
